// ----- rtl/ufs_pkg.sv -----
// Shared types and constants for the disjoint-set engine.
`default_nettype none

package ufs_pkg;

  // Field widths fixed at the block boundary.
  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 10;
  localparam int GSIZE_W = 11;

  // Default element count.
  localparam int NODES_DEFAULT = 1024;

  // Request operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_UNITE = 2'd0,
    FUNC_SAME  = 2'd1,
    FUNC_COUNT = 2'd2,
    FUNC_FIND  = 2'd3
  } func_t;

  // Operations of the shared compare/add unit.
  typedef enum logic [1:0] {
    ALU_EQ  = 2'd0,
    ALU_GT  = 2'd1,
    ALU_ADD = 2'd2
  } alu_op_t;

endpackage

`default_nettype wire

// ----- rtl/ufs_table.sv -----
// Single-port parent/size table with registered read data.
`default_nettype none

module ufs_table #(
  parameter int DEPTH = ufs_pkg::NODES_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = AW + $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ufs_alu.sv -----
// Shared compare and add unit used by the sequencer.
`default_nettype none

module ufs_alu #(
  parameter int W = 11
) (
  input  wire ufs_pkg::alu_op_t op,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic                  flag,
  output logic      [W-1:0]     sum
);

  always_comb begin
    flag = 1'b0;
    sum  = '0;
    unique case (op)
      ufs_pkg::ALU_EQ:  flag = (a == b);
      ufs_pkg::ALU_GT:  flag = (a > b);
      ufs_pkg::ALU_ADD: sum  = a + b;
      default: begin
        flag = 1'b0;
        sum  = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/union_find_by_size.sv -----
// Disjoint-set engine: union by size with path compression over NODES elements.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req     | in        | req_valid/req_ready  | func, node_a, node_b
//   rsp     | out       | rsp_valid/rsp_ready  | root_a, same_set, merged, group_size
//
// Sequence: one table access per cycle; a walk reads and checks each node to the root,
//   its compression reads and repoints each node below; find/count use one walk, same
//   two plus a root compare, unite two plus compare, size test, add, two link writes
//   (compare only on a shared root); each transaction adds accept and output-load steps.
// Reset: rst clears all NODES entries, one entry per cycle; req_ready stays low.
// Stalls: one transaction at a time; a finished result waits in the output register
//   while the next request is taken, and holds back that request's result and req_ready.
`default_nettype none

module union_find_by_size #(
  parameter int NODES = ufs_pkg::NODES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [ufs_pkg::FUNC_W-1:0]  func,
  input  wire logic [ufs_pkg::NODE_W-1:0]  node_a,
  input  wire logic [ufs_pkg::NODE_W-1:0]  node_b,
  // response channel
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic      [ufs_pkg::NODE_W-1:0]  root_a,
  output logic                             same_set,
  output logic                             merged,
  output logic      [ufs_pkg::GSIZE_W-1:0] group_size
);

  // Index width, set-size width (holds NODES itself) and table word width.
  localparam int IW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);
  localparam int DW = IW + SW;
  localparam logic [31:0] LAST = 32'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_COMP_RD,
    S_COMP_WR,
    S_JOIN_EQ,
    S_JOIN_GT,
    S_JOIN_ADD,
    S_LINK_LOSE,
    S_LINK_WIN,
    S_DONE
  } state_t;

  state_t state;

  // Sequencer registers.
  ufs_pkg::func_t op;
  logic [IW-1:0]  clr_cnt;
  logic [IW-1:0]  r;         // walk cursor, ends on the root
  logic [IW-1:0]  x;         // compression cursor
  logic [IW-1:0]  b_node;    // clamped second node, held for the second walk
  logic [SW-1:0]  rsize;     // size read at the root of the current walk
  logic           second;    // the current walk is the one for node_b
  logic [IW-1:0]  ra;
  logic [IW-1:0]  rb;
  logic [SW-1:0]  sa;
  logic [SW-1:0]  sb;
  logic [SW-1:0]  sum;
  logic           big;       // first root's set is strictly larger
  logic           same;
  logic           joined;

  // Table port.
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;
  logic [IW-1:0] rd_parent;
  logic [SW-1:0] rd_size;

  // Shared unit port.
  ufs_pkg::alu_op_t alu_op;
  logic [SW-1:0]    alu_a;
  logic [SW-1:0]    alu_b;
  logic             alu_flag;
  logic [SW-1:0]    alu_sum;

  // Clamped request nodes and masked result fields.
  logic [IW-1:0]                      a_clamp;
  logic [IW-1:0]                      b_clamp;
  logic [IW+ufs_pkg::NODE_W-1:0]      ra_wide;
  logic [SW+ufs_pkg::GSIZE_W-1:0]     sa_wide;

  assign a_clamp = (32'(node_a) > LAST) ? IW'(LAST) : IW'(node_a);
  assign b_clamp = (32'(node_b) > LAST) ? IW'(LAST) : IW'(node_b);
  assign ra_wide = {{ufs_pkg::NODE_W{1'b0}}, ra};
  assign sa_wide = {{ufs_pkg::GSIZE_W{1'b0}}, sa};

  assign rd_parent = mem_rdata[DW-1:SW];
  assign rd_size   = mem_rdata[SW-1:0];

  // Take a request only between transactions, after the clearing pass.
  assign req_ready = (state == S_IDLE);

  ufs_table #(
    .DEPTH (NODES),
    .AW    (IW),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ufs_alu #(
    .W (SW)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .flag (alu_flag),
    .sum  (alu_sum)
  );

  // Drive the table port and the shared unit from the current state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = r;
    mem_wdata = '0;
    alu_op    = ufs_pkg::ALU_EQ;
    alu_a     = '0;
    alu_b     = '0;
    unique case (state)
      S_CLEAR: begin
        // Point each entry at itself with a set size of one.
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = {clr_cnt, SW'(1)};
      end
      S_WALK_RD: begin
        mem_addr = r;
      end
      S_WALK_CHK: begin
        // A node that is its own parent is the root.
        alu_op = ufs_pkg::ALU_EQ;
        alu_a  = SW'(rd_parent);
        alu_b  = SW'(r);
      end
      S_COMP_RD: begin
        // Stop compressing once the cursor reaches the root; else fetch the node.
        alu_op   = ufs_pkg::ALU_EQ;
        alu_a    = SW'(x);
        alu_b    = SW'(r);
        mem_addr = x;
      end
      S_COMP_WR: begin
        // Repoint the node at the root, keep its stored size.
        mem_we    = 1'b1;
        mem_addr  = x;
        mem_wdata = {r, rd_size};
      end
      S_JOIN_EQ: begin
        alu_op = ufs_pkg::ALU_EQ;
        alu_a  = SW'(ra);
        alu_b  = SW'(rb);
      end
      S_JOIN_GT: begin
        alu_op = ufs_pkg::ALU_GT;
        alu_a  = sa;
        alu_b  = sb;
      end
      S_JOIN_ADD: begin
        alu_op = ufs_pkg::ALU_ADD;
        alu_a  = sa;
        alu_b  = sb;
      end
      S_LINK_LOSE: begin
        // Hang the smaller root under the larger; ties go under the second root.
        mem_we    = 1'b1;
        mem_addr  = big ? rb : ra;
        mem_wdata = big ? {ra, sb} : {rb, sa};
      end
      S_LINK_WIN: begin
        // The surviving root takes the combined size.
        mem_we    = 1'b1;
        mem_addr  = big ? ra : rb;
        mem_wdata = big ? {ra, sum} : {rb, sum};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer state and registered response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once it is taken, unless a new one loads in its place.
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (32'(clr_cnt) == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op     <= ufs_pkg::func_t'(func);
            r      <= a_clamp;
            x      <= a_clamp;
            b_node <= b_clamp;
            second <= 1'b0;
            same   <= 1'b0;
            joined <= 1'b0;
            state  <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (alu_flag) begin
            rsize <= rd_size;
            state <= S_COMP_RD;
          end else begin
            r     <= rd_parent;
            state <= S_WALK_RD;
          end
        end
        S_COMP_RD: begin
          if (!alu_flag) begin
            state <= S_COMP_WR;
          end else if (!second) begin
            ra <= r;
            sa <= rsize;
            if (op == ufs_pkg::FUNC_UNITE || op == ufs_pkg::FUNC_SAME) begin
              // Walk the second node next.
              second <= 1'b1;
              r      <= b_node;
              x      <= b_node;
              state  <= S_WALK_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            rb    <= r;
            sb    <= rsize;
            state <= S_JOIN_EQ;
          end
        end
        S_COMP_WR: begin
          x     <= rd_parent;
          state <= S_COMP_RD;
        end
        S_JOIN_EQ: begin
          same <= alu_flag;
          if (alu_flag || op == ufs_pkg::FUNC_SAME) begin
            state <= S_DONE;
          end else begin
            state <= S_JOIN_GT;
          end
        end
        S_JOIN_GT: begin
          big   <= alu_flag;
          state <= S_JOIN_ADD;
        end
        S_JOIN_ADD: begin
          sum   <= alu_sum;
          state <= S_LINK_LOSE;
        end
        S_LINK_LOSE: begin
          state <= S_LINK_WIN;
        end
        S_LINK_WIN: begin
          ra     <= big ? ra : rb;
          sa     <= sum;
          joined <= 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!rsp_valid || rsp_ready) begin
            rsp_valid  <= 1'b1;
            root_a     <= ra_wide[ufs_pkg::NODE_W-1:0];
            group_size <= sa_wide[ufs_pkg::GSIZE_W-1:0];
            same_set   <= same;
            merged     <= joined;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The table is never written between transactions.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  // An accepted transaction always starts with a root walk.
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_WALK_RD))
    else $error("accepted transaction did not start a walk");

  // A merge only ever joins two distinct roots.
  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK_LOSE || state == S_LINK_WIN) |-> (ra != rb))
    else $error("link between equal roots");

  // A response never reports both a merge and a shared root.
  a_rsp_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(merged && same_set))
    else $error("merged and same_set both set");
`endif

endmodule

`default_nettype wire

// ----- dv/union_find_checker.sv -----
// Checker for the disjoint-set engine: predicts every response and compares it.

module union_find_checker #(
  parameter int NODES = ufs_pkg::NODES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  logic [ufs_pkg::FUNC_W-1:0]  func,
  input  logic [ufs_pkg::NODE_W-1:0]  node_a,
  input  logic [ufs_pkg::NODE_W-1:0]  node_b,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  logic [ufs_pkg::NODE_W-1:0]  root_a,
  input  logic                        same_set,
  input  logic                        merged,
  input  logic [ufs_pkg::GSIZE_W-1:0] group_size,
  input  logic                        end_check,
  output int                          errors,
  output int                          pending,
  output int                          largest_set
);

  // Expected responses in flight; the block holds at most two at a time.
  localparam int RING = 16;

  typedef struct {
    int                          seq;
    ufs_pkg::func_t              op;
    logic [ufs_pkg::NODE_W-1:0]  root;
    logic                        same;
    logic                        joined;
    logic [ufs_pkg::GSIZE_W-1:0] members;
  } set_answer_t;

  int          forest_parent [NODES];
  int          forest_size   [NODES];
  set_answer_t answer_ring [RING];
  int          wr_count;
  int          rd_count;
  int          req_seq;
  bit          leftovers_checked;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors = errors + 1;
  endtask

  function automatic int clamp_index(input int v);
    return (v >= NODES) ? NODES - 1 : v;
  endfunction

  // Walk up to the root, then point every node on the path straight at it.
  function automatic int find_and_compress(input int start);
    int top;
    int node;
    int nxt;
    int steps;
    top = start;
    steps = 0;
    while (forest_parent[top] != top && steps < NODES) begin
      top = forest_parent[top] % NODES;
      steps++;
    end
    node = start;
    steps = 0;
    while (node != top && steps < NODES) begin
      nxt = forest_parent[node] % NODES;
      forest_parent[node] = top;
      node = nxt;
      steps++;
    end
    return top;
  endfunction

  task automatic predict_request(input ufs_pkg::func_t op, input int a, input int b);
    set_answer_t ans;
    int ra;
    int rb;
    bit shared;
    bit joined;
    ra = find_and_compress(clamp_index(a));
    shared = 1'b0;
    joined = 1'b0;
    if (op == ufs_pkg::FUNC_UNITE || op == ufs_pkg::FUNC_SAME) begin
      rb = find_and_compress(clamp_index(b));
      shared = (ra == rb);
      if (op == ufs_pkg::FUNC_UNITE && !shared) begin
        // Larger root wins; a tie hangs the first root under the second.
        if (forest_size[ra] > forest_size[rb]) begin
          forest_parent[rb] = ra;
          forest_size[ra] += forest_size[rb];
        end else begin
          forest_parent[ra] = rb;
          forest_size[rb] += forest_size[ra];
          ra = rb;
        end
        joined = 1'b1;
      end
    end
    ans.seq     = req_seq;
    ans.op      = op;
    ans.root    = ufs_pkg::NODE_W'(ra);
    ans.same    = shared;
    ans.joined  = joined;
    ans.members = ufs_pkg::GSIZE_W'(forest_size[ra]);
    if (forest_size[ra] > largest_set)
      largest_set = forest_size[ra];
    if (wr_count - rd_count >= RING) begin
      report("more responses outstanding than the block can hold");
    end else begin
      answer_ring[wr_count % RING] = ans;
      wr_count++;
    end
    req_seq++;
  endtask

  always @(posedge clk) begin
    set_answer_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        forest_parent[i] = i;
        forest_size[i]   = 1;
      end
      wr_count          = 0;
      rd_count          = 0;
      errors            = 0;
      largest_set       = 1;
      req_seq           = 0;
      leftovers_checked = 1'b0;
      pending <= 0;
    end else begin
      if (req_valid && req_ready)
        predict_request(ufs_pkg::func_t'(func), int'(node_a), int'(node_b));
      if (rsp_valid && rsp_ready) begin
        if (wr_count == rd_count) begin
          report("response with no request outstanding");
        end else begin
          want = answer_ring[rd_count % RING];
          rd_count++;
          if (root_a !== want.root)
            report($sformatf("#%0d %s root_a got %0d expected %0d",
                             want.seq, want.op.name(), root_a, want.root));
          if (same_set !== want.same)
            report($sformatf("#%0d %s same_set got %0b expected %0b",
                             want.seq, want.op.name(), same_set, want.same));
          if (merged !== want.joined)
            report($sformatf("#%0d %s merged got %0b expected %0b",
                             want.seq, want.op.name(), merged, want.joined));
          if (group_size !== want.members)
            report($sformatf("#%0d %s group_size got %0d expected %0d",
                             want.seq, want.op.name(), group_size, want.members));
        end
      end
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (wr_count != rd_count)
          report($sformatf("%0d responses never arrived", wr_count - rd_count));
      end
      pending <= wr_count - rd_count;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the disjoint-set engine testbench: clock, reset, stimulus and verdict.

module testbench;

  // Hard limit on the run length, with wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // Longest single request (unite, two deep walks plus compression) with margin.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_TAIL    = 100;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic [ufs_pkg::FUNC_W-1:0]  req_func = ufs_pkg::FUNC_FIND;
  logic [ufs_pkg::NODE_W-1:0]  req_node_a = '0;
  logic [ufs_pkg::NODE_W-1:0]  req_node_b = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic [ufs_pkg::NODE_W-1:0]  rsp_root_a;
  logic                        rsp_same_set;
  logic                        rsp_merged;
  logic [ufs_pkg::GSIZE_W-1:0] rsp_group_size;
  logic                        end_check = 1'b0;

  int errors;
  int pending;
  int largest_set;
  int cycles = 0;
  int op_count [4] = '{default: 0};
  int stall_left = 0;
  int window_base = 0;
  bit idle_on = 1'b1;

  union_find_by_size dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .func       (req_func),
    .node_a     (req_node_a),
    .node_b     (req_node_b),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .root_a     (rsp_root_a),
    .same_set   (rsp_same_set),
    .merged     (rsp_merged),
    .group_size (rsp_group_size)
  );

  union_find_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .func        (req_func),
    .node_a      (req_node_a),
    .node_b      (req_node_b),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .root_a      (rsp_root_a),
    .same_set    (rsp_same_set),
    .merged      (rsp_merged),
    .group_size  (rsp_group_size),
    .end_check   (end_check),
    .errors      (errors),
    .pending     (pending),
    .largest_set (largest_set)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs anywhere, including the clearing pass after reset.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Response side back-pressure: drop ready for random bursts while idling is
  // enabled, hold it high otherwise.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Present one request and hold it until the transaction is accepted. Every call
  // starts and ends on a rising edge, so valid gets one update per edge.
  task automatic send_req(input ufs_pkg::func_t op, input logic [ufs_pkg::NODE_W-1:0] a,
                          input logic [ufs_pkg::NODE_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_func   <= op;
    req_node_a <= a;
    req_node_b <= b;
    do @(posedge clk); while (!req_ready);
    op_count[op]++;
  endtask

  // Half the picks land in a 64-node window so sets grow large and trees deep;
  // the rest spread over the whole index range.
  function automatic logic [ufs_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(0, 1) == 0)
      return ufs_pkg::NODE_W'(window_base + $urandom_range(0, 63));
    return ufs_pkg::NODE_W'($urandom_range(0, ufs_pkg::NODES_DEFAULT - 1));
  endfunction

  function automatic ufs_pkg::func_t pick_op();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return ufs_pkg::FUNC_UNITE;
    if (roll < 6) return ufs_pkg::FUNC_SAME;
    if (roll < 8) return ufs_pkg::FUNC_COUNT;
    return ufs_pkg::FUNC_FIND;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: index extremes, every operation, tie-break, larger-root-wins,
    // unite of an already joined pair, self unite, ignored node_b.
    send_req(ufs_pkg::FUNC_FIND,  10'd0,    10'd1023);
    send_req(ufs_pkg::FUNC_FIND,  10'd1023, 10'd0);
    send_req(ufs_pkg::FUNC_COUNT, 10'd1023, 10'd1023);
    send_req(ufs_pkg::FUNC_SAME,  10'd0,    10'd1023);
    send_req(ufs_pkg::FUNC_UNITE, 10'd0,    10'd1023);  // equal sizes: 0 goes under 1023
    send_req(ufs_pkg::FUNC_UNITE, 10'd0,    10'd1023);  // already joined
    send_req(ufs_pkg::FUNC_SAME,  10'd1023, 10'd0);
    send_req(ufs_pkg::FUNC_COUNT, 10'd0,    10'd5);
    send_req(ufs_pkg::FUNC_UNITE, 10'd5,    10'd0);     // smaller first root goes under
    send_req(ufs_pkg::FUNC_UNITE, 10'd1023, 10'd6);     // larger first root keeps the root
    send_req(ufs_pkg::FUNC_UNITE, 10'h2AA,  10'h2AA);   // self unite
    send_req(ufs_pkg::FUNC_UNITE, 10'h155,  10'h2AA);
    send_req(ufs_pkg::FUNC_UNITE, 10'h2AA,  10'd0);
    send_req(ufs_pkg::FUNC_FIND,  10'h155,  10'h3FF);
    send_req(ufs_pkg::FUNC_COUNT, 10'h155,  10'h000);
    send_req(ufs_pkg::FUNC_SAME,  10'h155,  10'd6);
    send_req(ufs_pkg::FUNC_SAME,  10'h2AA,  10'h155);
    send_req(ufs_pkg::FUNC_FIND,  10'h2AA,  10'h155);
    send_req(ufs_pkg::FUNC_COUNT, 10'd512,  10'd511);
    send_req(ufs_pkg::FUNC_UNITE, 10'd511,  10'd512);

    // Random: idling on and off in stretches of 60, none in the tail.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0)
        window_base = $urandom_range(0, ufs_pkg::NODES_DEFAULT - 64);
      idle_on = (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 60) % 3 != 2);
      send_req(pick_op(), pick_node(), pick_node());
    end
    req_valid <= 1'b0;

    // Drain: let the pending count catch up, wait for it to clear, then settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d unite, %0d same, %0d count and %0d find requests",
             op_count[ufs_pkg::FUNC_UNITE], op_count[ufs_pkg::FUNC_SAME],
             op_count[ufs_pkg::FUNC_COUNT], op_count[ufs_pkg::FUNC_FIND]);
    $display("Largest set built: %0d elements, run took %0d cycles", largest_set, cycles);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ufs_pkg.sv
rtl/ufs_table.sv
rtl/ufs_alu.sv
rtl/union_find_by_size.sv
dv/union_find_checker.sv
dv/testbench.sv
